@@ hdl/kclp_pkg.sv @@
package kclp_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int LIMIT_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CLICK_MIN_TICKS = 2;
   localparam logic [LIMIT_BITS-1:0] LONG_PRESS_RESET = 16'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE       = 2'd0,
      CSR_LONG_PRESS = 2'd1
   } csr_index_type;

   typedef enum logic {
      MODE_KEY   = 1'b0,
      MODE_CHECK = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_CLICK = 3'd1,
      EV_LONG  = 3'd2,
      EV_UP    = 3'd3,
      EV_DOWN  = 3'd4
   } event_type;

   typedef struct packed {
      logic wait_release;
      logic present_flag;
   } flags_type;

endpackage

@@ hdl/kclp_core.sv @@
module kclp_core
   import kclp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  mode_type                  mode,
   input  logic [LIMIT_BITS-1:0]     long_press_ticks,
   input  logic                      key_level,
   input  logic [COUNT_BITS-1:0]     held_ticks,
   input  flags_type                 flags,
   output logic [COUNT_BITS-1:0]     held_ticks_next,
   output flags_type                 flags_next,
   output event_type                 event_res
);

   localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   logic [COUNT_BITS-1:0] held_inc;
   logic [COUNT_BITS-1:0] held_chk;
   logic                  over_limit;

   // saturating increment
   assign held_inc = (held_ticks == {COUNT_BITS{1'b1}}) ? held_ticks
                                                         : held_ticks + COUNT_BITS'(1);
   assign over_limit = CMP_BITS'(held_inc) > CMP_BITS'(long_press_ticks);
   // check mode: a pending wait eats the first disagreement instead of counting
   assign held_chk = flags.wait_release ? held_ticks : held_inc;

   always_comb begin
      held_ticks_next = held_ticks;
      flags_next      = flags;
      event_res       = EV_NONE;
      case (mode)
         MODE_KEY: begin
            if (key_level) begin
               if (!flags.wait_release) begin
                  if (over_limit) begin
                     flags_next.wait_release = 1'b1;
                     held_ticks_next         = '0;
                     event_res               = EV_LONG;
                  end else begin
                     held_ticks_next = held_inc;
                  end
               end
            end else if (flags.wait_release) begin
               flags_next.wait_release = 1'b0;
               held_ticks_next         = '0;
            end else if (held_ticks >= COUNT_BITS'(CLICK_MIN_TICKS)) begin
               flags_next.wait_release = 1'b1;
               held_ticks_next         = '0;
               event_res               = EV_CLICK;
            end
         end
         MODE_CHECK: begin
            if (key_level != flags.present_flag) begin
               flags_next.wait_release = 1'b0;
               if (held_chk >= COUNT_BITS'(CLICK_MIN_TICKS)) begin
                  held_ticks_next         = '0;
                  flags_next.present_flag = key_level;
                  event_res               = key_level ? EV_UP : EV_DOWN;
               end else begin
                  held_ticks_next = held_chk;
               end
            end
         end
         default: begin
            held_ticks_next = held_ticks;
         end
      endcase
   end

endmodule

@@ hdl/kclp_out_queue.sv @@
module kclp_out_queue
   import kclp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  event_type  push_event,
   output logic       has_room,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output event_type  rsp_event
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   event_type  head_ff;
   event_type  head_in;
   event_type  skid_ff;
   event_type  skid_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_event = head_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign has_room  = (count_ff != 2'd2) || pop;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      if (pop && push) begin
         if (count_ff == 2'd2) begin
            head_in = skid_ff;
            skid_in = push_event;
         end else begin
            head_in = push_event;
         end
      end else if (pop) begin
         head_in  = skid_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_event;
         end else begin
            skid_in = push_event;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

@@ hdl/key_click_long_press_detector.sv @@
// Key click / long press detector. One sampled key level goes in per item and one event
// code comes out per item (0 none, 1 click, 2 long press, 3 up, 4 down). Mode 0 counts
// held ticks and reports a long press once the count exceeds long_press_ticks, or a click
// on release after two or more held ticks; mode 1 flips a presence flag after two ticks
// of disagreement and reports up or down. An item is taken every cycle while the result
// queue has room; its event passes from the input register through the state update into
// a two-entry result queue, which keeps the input side moving while a result waits. Write
// configuration only while the block is idle.
module key_click_long_press_detector
   import kclp_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_key_level,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [2:0]                rsp_event_res,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LIMIT_BITS-1:0]     csr_data
);

   mode_type              mode_ff;
   logic [LIMIT_BITS-1:0] long_press_ff;
   logic                  in_valid_ff;
   logic                  in_level_ff;
   logic [COUNT_BITS-1:0] held_ticks_ff;
   logic [COUNT_BITS-1:0] held_ticks_in;
   flags_type             flags_ff;
   flags_type             flags_in;
   event_type             step_event;
   event_type             out_event;
   logic                  has_room;
   logic                  move;

   assign csr_ready = 1'b1;
   assign move      = in_valid_ff && has_room;
   assign req_ready = !in_valid_ff || has_room;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_KEY;
         long_press_ff <= LONG_PRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:       mode_ff       <= mode_type'(csr_data[0]);
            CSR_LONG_PRESS: long_press_ff <= csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_level_ff <= req_key_level;
      end
   end

   kclp_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .mode             (mode_ff),
      .long_press_ticks (long_press_ff),
      .key_level        (in_level_ff),
      .held_ticks       (held_ticks_ff),
      .flags            (flags_ff),
      .held_ticks_next  (held_ticks_in),
      .flags_next       (flags_in),
      .event_res        (step_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ticks_ff <= '0;
         flags_ff      <= '0;
      end else if (move) begin
         held_ticks_ff <= held_ticks_in;
         flags_ff      <= flags_in;
      end
   end

   kclp_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (move),
      .push_event (step_event),
      .has_room   (has_room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_event  (out_event)
   );

   assign rsp_event_res = out_event;

`ifndef SYNTH
   a_long_sets_wait: assert property (@(posedge clock) disable iff (reset)
      (move && step_event == EV_LONG) |=> (flags_ff.wait_release && held_ticks_ff == '0))
      else $error("long press did not enter wait state");

   a_event_clears_count: assert property (@(posedge clock) disable iff (reset)
      (move && step_event != EV_NONE) |=> (held_ticks_ff == '0))
      else $error("counter not cleared after event");

   a_full_queue_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      (!has_room) |=> rsp_valid)
      else $error("result lost from full queue");

   a_no_move_holds_state: assert property (@(posedge clock) disable iff (reset)
      (!move) |=> ($stable(held_ticks_ff) && $stable(flags_ff)))
      else $error("state changed without an item");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import kclp_pkg::*;

   localparam int COUNT_W = COUNT_BITS_DEFAULT;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_key_level = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_event_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [LIMIT_BITS-1:0] csr_data = '0;

   // detector state as the testbench sees it
   logic [COUNT_W-1:0] hold_count = '0;
   bit await_release = 1'b0;
   bit key_present = 1'b0;
   mode_type cur_mode = MODE_KEY;
   logic [LIMIT_BITS-1:0] lp_limit = LONG_PRESS_RESET;

   event_type pending_events[$];
   event_type want_event;
   bit no_idle = 1'b0;
   int error_count = 0;
   int item_count = 0;
   int csr_count = 0;
   int cycle_count = 0;
   int click_count = 0;
   int long_count = 0;
   int up_count = 0;
   int down_count = 0;

   key_click_long_press_detector u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_level (req_key_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_event_res (rsp_event_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // next event for one sampled level; updates the tracked state
   function automatic event_type key_event_next(input logic lvl);
      event_type ev;
      ev = EV_NONE;
      if (cur_mode == MODE_KEY) begin
         if (lvl) begin
            if (!await_release) begin
               if (hold_count != COUNT_TOP) hold_count++;
               if (hold_count > lp_limit) begin
                  await_release = 1'b1;
                  hold_count = '0;
                  ev = EV_LONG;
               end
            end
         end else if (await_release) begin
            await_release = 1'b0;
            hold_count = '0;
         end else if (hold_count >= CLICK_MIN_TICKS) begin
            // a single held tick leaves the count in place
            await_release = 1'b1;
            hold_count = '0;
            ev = EV_CLICK;
         end
      end else if (lvl != key_present) begin
         // a pending release absorbs the first disagreement
         if (await_release) await_release = 1'b0;
         else if (hold_count != COUNT_TOP) hold_count++;
         if (hold_count >= CLICK_MIN_TICKS) begin
            hold_count = '0;
            key_present = lvl;
            ev = lvl ? EV_UP : EV_DOWN;
         end
      end
      return ev;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic send_level(input logic lvl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_level <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_events.push_back(key_event_next(lvl));
      item_count++;
   endtask

   task automatic send_run(input logic lvl, input int n);
      repeat (n) send_level(lvl);
   endtask

   // called right after an item is accepted, so valid drops in that step
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [LIMIT_BITS-1:0] data);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_count++;
      case (idx)
         CSR_MODE:       cur_mode = mode_type'(data[0]);
         CSR_LONG_PRESS: lp_limit = data;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : rsp_stall
      int stall_left;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected item, event %0d", rsp_event_res));
         end else begin
            want_event = pending_events.pop_front();
            if (rsp_event_res !== want_event)
               report_mismatch($sformatf("event_res got %0d want %0d (%s)",
                                         rsp_event_res, want_event, want_event.name()));
            case (want_event)
               EV_CLICK: click_count++;
               EV_LONG:  long_count++;
               EV_UP:    up_count++;
               EV_DOWN:  down_count++;
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d items outstanding",
                  cycle_count, pending_events.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_click_and_release();
      send_run(1'b1, 2);
      send_run(1'b0, 2);
      drain_results();
   endtask

   task automatic test_single_tick_press();
      send_level(1'b1);
      send_level(1'b0);
      send_level(1'b1);
      send_run(1'b0, 2);
      drain_results();
   endtask

   // runs on the reset limit, so it must precede any limit write
   task automatic test_reset_limit();
      send_run(1'b1, int'(LONG_PRESS_RESET) + 1);
      send_level(1'b0);
      drain_results();
   endtask

   task automatic test_long_press_limits();
      csr_write(CSR_LONG_PRESS, 16'd0);
      send_run(1'b1, 2);
      send_level(1'b0);
      csr_write(CSR_LONG_PRESS, 16'd3);
      send_run(1'b1, 5);
      send_level(1'b0);
      drain_results();
   endtask

   task automatic test_unused_index();
      csr_write(CSR_SPARE_A, 16'hFFFF);
      csr_write(CSR_SPARE_B, 16'h0000);
      send_run(1'b1, 4);
      send_level(1'b0);
      drain_results();
   endtask

   task automatic test_check_mode();
      csr_write(CSR_MODE, 16'hFFFF);
      send_run(1'b1, 2);
      send_level(1'b0);
      send_level(1'b1);
      send_level(1'b0);
      drain_results();
   endtask

   task automatic test_mode_carry_over();
      csr_write(CSR_MODE, 16'(MODE_KEY));
      send_run(1'b1, 2);
      send_level(1'b0);
      // pending release crosses into check mode
      csr_write(CSR_MODE, 16'(MODE_CHECK));
      send_run(1'b1, 3);
      // one held tick crosses back and counts as a disagreement
      csr_write(CSR_MODE, 16'(MODE_KEY));
      send_level(1'b1);
      send_level(1'b0);
      csr_write(CSR_MODE, 16'(MODE_CHECK));
      send_level(1'b0);
      drain_results();
   endtask

   // limits at the top of the range, sent back to back
   task automatic test_large_limit();
      no_idle = 1'b1;
      csr_write(CSR_MODE, 16'(MODE_KEY));
      csr_write(CSR_LONG_PRESS, 16'hFFFF);
      send_run(1'b1, 40);
      send_run(1'b0, 2);
      csr_write(CSR_LONG_PRESS, 16'hFFFE);
      send_run(1'b1, 40);
      send_run(1'b0, 2);
      drain_results();
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic(input int n_items);
      int stop_at;
      int phase_end;
      int r;
      int max_hold;
      logic [LIMIT_BITS-1:0] limit_val;
      logic [LIMIT_BITS-1:0] mode_val;
      stop_at = item_count + n_items;
      while (item_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 8) limit_val = '0;
         else if (r < 13) limit_val = '1;
         else if (r < 20) limit_val = 16'($urandom_range(0, 65535));
         else if (r < 35) limit_val = 16'($urandom_range(7, 40));
         else limit_val = 16'($urandom_range(1, 6));
         mode_val = 16'($urandom_range(0, 65535));
         mode_val[0] = ($urandom_range(0, 99) < 30);
         if ($urandom_range(0, 1)) begin
            csr_write(CSR_LONG_PRESS, limit_val);
            csr_write(CSR_MODE, mode_val);
         end else begin
            csr_write(CSR_MODE, mode_val);
            csr_write(CSR_LONG_PRESS, limit_val);
         end
         if ($urandom_range(0, 7) == 0)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      16'($urandom_range(0, 65535)));
         no_idle = ($urandom_range(0, 4) == 0);
         phase_end = item_count + $urandom_range(30, 120);
         while (item_count < phase_end) begin
            if ($urandom_range(0, 49) == 0) drain_results();
            r = $urandom_range(0, 99);
            if (r >= 85) begin
               send_level(1'($urandom_range(0, 1)));
            end else if (cur_mode == MODE_KEY) begin
               max_hold = (lp_limit < 8) ? int'(lp_limit) + 3 : 8;
               send_run(1'b1, $urandom_range(1, max_hold));
               send_run(1'b0, $urandom_range(1, 3));
            end else begin
               send_run(1'($urandom_range(0, 1)), $urandom_range(1, 4));
            end
         end
      end
      drain_results();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_click_and_release();
      test_single_tick_press();
      test_reset_limit();
      test_long_press_limits();
      test_unused_index();
      test_check_mode();
      test_mode_carry_over();
      test_large_limit();
      test_random_traffic(700);
      drain_results();
      repeat (10) @(posedge clock);
      $display("Run covered %0d items and %0d register writes in both modes",
               item_count, csr_count);
      $display("Events seen: %0d click, %0d long press, %0d up, %0d down",
               click_count, long_count, up_count, down_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
